// ===== rtl/cda_pkg.sv =====
// shared types, constants and calendar helpers for the calendar date adder
`default_nettype none
package cda_pkg;

  localparam int OP_W    = 3;
  localparam int COUNT_W = 15;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 15;

  localparam int DEFAULT_YEAR_BITS  = 15;
  localparam int DEFAULT_COUNT_BITS = 15;

  localparam int MONTHS_PER_YEAR  = 12;
  localparam int DAYS_PER_WEEK    = 7;
  localparam int CENTURY_YEARS    = 100;
  localparam int MILLENNIUM_YEARS = 1000;
  localparam int LEAP_FEB_DAYS    = 29;

  // multiple of 25 test: times the inverse of 25 mod 2^16, multiples land at or below the limit
  localparam int LEAP_CHK_W = 16;
  localparam logic [LEAP_CHK_W-1:0] DIV25_INV   = 16'h5c29;
  localparam logic [LEAP_CHK_W-1:0] DIV25_LIMIT = 16'd2621;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(MONTHS_PER_YEAR);

  localparam logic [DAY_W-1:0] MONTH_LEN [MONTHS_PER_YEAR] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [OP_W-1:0] {
    OP_LOAD,
    OP_DAYS,
    OP_WEEKS,
    OP_MONTHS,
    OP_YEARS,
    OP_DECADES,
    OP_CENTURY,
    OP_MILLENNIUM
  } op_e;

  typedef struct packed {
    logic start;
    logic day_step;
    logic month_step;
    logic fix_day;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
  } status_t;

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
    logic [DAY_W-1:0] len;
    logic [MONTH_W-1:0] idx;
    idx = month - MONTH_JAN;
    if (month == MONTH_FEB && leap) begin
      len = DAY_W'(LEAP_FEB_DAYS);
    end else if (month >= MONTH_JAN && month <= MONTH_DEC) begin
      len = MONTH_LEN[idx];
    end else begin
      len = MONTH_LEN[0];
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/calendar_date_adder.sv =====
// top level of the calendar date adder: controller and datapath
//
//   channel  direction  handshake             word
//   in       input      in_valid_i/in_stall_o  op, count, load date
//   out      output     out_valid_o/out_stall_i day, month, year, overflow
//
// one word at a time; a day or week command steps count (or 7*count) days,
// one day per cycle, and a month command steps count months, one month per cycle
// load and year commands pass through a state that clamps the day
// the result register lets the next word be taken while a result waits on out_stall_i
// reset gives 1 january of year 0 with no result pending
`default_nettype none
module calendar_date_adder #(
  parameter int YEAR_BITS  = cda_pkg::DEFAULT_YEAR_BITS,
  parameter int COUNT_BITS = cda_pkg::DEFAULT_COUNT_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [cda_pkg::OP_W-1:0]     op_i,
  input  wire logic [cda_pkg::COUNT_W-1:0]  count_i,
  input  wire logic [cda_pkg::DAY_W-1:0]    load_day_i,
  input  wire logic [cda_pkg::MONTH_W-1:0]  load_month_i,
  input  wire logic [cda_pkg::YEAR_W-1:0]   load_year_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [cda_pkg::DAY_W-1:0]    day_out_o,
  output logic      [cda_pkg::MONTH_W-1:0]  month_out_o,
  output logic      [cda_pkg::YEAR_W-1:0]   year_out_o,
  output logic                              overflow_o
);
  import cda_pkg::*;

  cmd_t    cmd;
  status_t status;

  cda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  cda_dp #(
    .YEAR_BITS  (YEAR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .op_i         (op_i),
    .count_i      (count_i),
    .load_day_i   (load_day_i),
    .load_month_i (load_month_i),
    .load_year_i  (load_year_i),
    .day_out_o    (day_out_o),
    .month_out_o  (month_out_o),
    .year_out_o   (year_out_o),
    .overflow_o   (overflow_o)
  );

endmodule
`default_nettype wire

// ===== rtl/cda_dp.sv =====
// datapath: date registers, step logic, year adder, leap test, result register
`default_nettype none
module cda_dp #(
  parameter int YEAR_BITS  = cda_pkg::DEFAULT_YEAR_BITS,
  parameter int COUNT_BITS = cda_pkg::DEFAULT_COUNT_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cda_pkg::cmd_t                cmd_i,
  output cda_pkg::status_t                  status_o,
  input  wire logic [cda_pkg::OP_W-1:0]     op_i,
  input  wire logic [cda_pkg::COUNT_W-1:0]  count_i,
  input  wire logic [cda_pkg::DAY_W-1:0]    load_day_i,
  input  wire logic [cda_pkg::MONTH_W-1:0]  load_month_i,
  input  wire logic [cda_pkg::YEAR_W-1:0]   load_year_i,
  output logic      [cda_pkg::DAY_W-1:0]    day_out_o,
  output logic      [cda_pkg::MONTH_W-1:0]  month_out_o,
  output logic      [cda_pkg::YEAR_W-1:0]   year_out_o,
  output logic                              overflow_o
);
  import cda_pkg::*;

  localparam int CNT_W  = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
  localparam int STEP_W = CNT_W + 3;
  localparam int ADD_W  = CNT_W + 4;
  localparam int SUM_W  = ((YEAR_BITS > ADD_W) ? YEAR_BITS : ADD_W) + 1;
  localparam int LD_W   = (YEAR_BITS > YEAR_W) ? YEAR_BITS : YEAR_W;
  localparam logic [YEAR_BITS-1:0] YMAX = '1;

  logic [DAY_W-1:0]     day_q, day_d;
  logic [MONTH_W-1:0]   month_q, month_d;
  logic [YEAR_BITS-1:0] year_q, year_d;
  logic [STEP_W-1:0]    cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;

  logic [DAY_W-1:0]     day_out_q;
  logic [MONTH_W-1:0]   month_out_q;
  logic [YEAR_W-1:0]    year_out_q;
  logic                 ovf_out_q;

  logic [CNT_W-1:0]      cnt_in;
  logic [LEAP_CHK_W-1:0] div25_prod;
  logic                  year_div25;
  logic                  leap;
  logic [DAY_W-1:0]      dim_cur;
  logic [DAY_W-1:0]      dim_next;
  logic [ADD_W-1:0]      addend;
  logic [SUM_W-1:0]      sum;
  logic [MONTH_W-1:0]    ld_month;
  logic [MONTH_W-1:0]    month_inc;

  assign cnt_in     = count_i[CNT_W-1:0];
  assign div25_prod = LEAP_CHK_W'(year_q) * DIV25_INV;
  assign year_div25 = (div25_prod <= DIV25_LIMIT);
  assign leap       = (year_q[1:0] == 2'b00) && (!year_div25 || (year_q[3:0] == 4'b0000));
  assign dim_cur    = month_length(month_q, leap);
  assign month_inc  = month_q + MONTH_W'(1);
  assign dim_next   = month_length(month_inc, leap);
  assign status_o.cnt_zero = (cnt_q == '0);

  always_comb begin
    case (op_e'(op_i))
      OP_YEARS:     addend = ADD_W'(cnt_in);
      OP_DECADES:   addend = (ADD_W'(cnt_in) << 3) + (ADD_W'(cnt_in) << 1);
      OP_CENTURY:   addend = ADD_W'(CENTURY_YEARS);
      default:      addend = ADD_W'(MILLENNIUM_YEARS);
    endcase
    sum = SUM_W'(year_q) + SUM_W'(addend);

    if (load_month_i < MONTH_JAN) begin
      ld_month = MONTH_JAN;
    end else if (load_month_i > MONTH_DEC) begin
      ld_month = MONTH_DEC;
    end else begin
      ld_month = load_month_i;
    end
  end

  always_comb begin
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;

    if (cmd_i.start) begin
      ovf_d = 1'b0;
      case (op_e'(op_i))
        OP_LOAD: begin
          day_d   = load_day_i;
          month_d = ld_month;
          if (LD_W'(load_year_i) > LD_W'(YMAX)) begin
            year_d = YMAX;
            ovf_d  = 1'b1;
          end else begin
            year_d = YEAR_BITS'(load_year_i);
          end
        end
        OP_DAYS, OP_MONTHS: begin
          cnt_d = STEP_W'(cnt_in);
        end
        OP_WEEKS: begin
          cnt_d = (STEP_W'(cnt_in) << 3) - STEP_W'(cnt_in);
        end
        default: begin
          if (sum > SUM_W'(YMAX)) begin
            year_d = YMAX;
            ovf_d  = 1'b1;
          end else begin
            year_d = YEAR_BITS'(sum);
          end
        end
      endcase
    end

    if (cmd_i.day_step) begin
      cnt_d = cnt_q - STEP_W'(1);
      if (day_q >= dim_cur) begin
        if (month_q >= MONTH_DEC) begin
          if (year_q == YMAX) begin
            ovf_d = 1'b1;
            cnt_d = '0;
          end else begin
            day_d   = DAY_W'(1);
            month_d = MONTH_JAN;
            year_d  = year_q + YEAR_BITS'(1);
          end
        end else begin
          day_d   = DAY_W'(1);
          month_d = month_inc;
        end
      end else begin
        day_d = day_q + DAY_W'(1);
      end
    end

    if (cmd_i.month_step) begin
      cnt_d = cnt_q - STEP_W'(1);
      if (month_q >= MONTH_DEC) begin
        if (year_q == YMAX) begin
          ovf_d = 1'b1;
          cnt_d = '0;
        end else begin
          month_d = MONTH_JAN;
          year_d  = year_q + YEAR_BITS'(1);
        end
      end else begin
        month_d = month_inc;
        if (day_q > dim_next) begin
          day_d = dim_next;
        end
      end
    end

    // clamp to 1 .. month length, also turns 29 feb into 28 in a common year
    if (cmd_i.fix_day) begin
      if (day_q < DAY_W'(1)) begin
        day_d = DAY_W'(1);
      end else if (day_q > dim_cur) begin
        day_d = dim_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q   <= DAY_W'(1);
      month_q <= MONTH_JAN;
      year_q  <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      day_out_q   <= day_q;
      month_out_q <= month_q;
      year_out_q  <= YEAR_W'(year_q);
      ovf_out_q   <= ovf_q;
    end
  end

  assign day_out_o   = day_out_q;
  assign month_out_o = month_out_q;
  assign year_out_o  = year_out_q;
  assign overflow_o  = ovf_out_q;

endmodule
`default_nettype wire

// ===== rtl/cda_ctrl.sv =====
// controller: command sequencing and handshakes on both channels
`default_nettype none
module cda_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [cda_pkg::OP_W-1:0]  op_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output cda_pkg::cmd_t                  cmd_o,
  input  wire cda_pkg::status_t          status_i
);
  import cda_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAY,
    S_MONTH,
    S_FIX,
    S_DONE
  } state_e;

  state_e           state_q;
  logic             out_valid_q;
  logic             accept;
  logic             out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.start      = accept;
    cmd_o.day_step   = (state_q == S_DAY) && !status_i.cnt_zero;
    cmd_o.month_step = (state_q == S_MONTH) && !status_i.cnt_zero;
    cmd_o.fix_day    = (state_q == S_FIX);
    cmd_o.publish    = (state_q == S_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_o.publish || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op_e'(op_i))
              OP_DAYS, OP_WEEKS: state_q <= S_DAY;
              OP_MONTHS:         state_q <= S_MONTH;
              default:           state_q <= S_FIX;
            endcase
          end
        end
        S_DAY, S_MONTH: begin
          if (status_i.cnt_zero) begin
            state_q <= S_DONE;
          end
        end
        S_FIX: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
